@@ design/hcc_pkg.sv @@
package hcc_pkg;

    // Channel full scale. A channel level is CHANNEL_MAX minus its pulse width.
    localparam int CHANNEL_MAX = 255;

    localparam int PULSE_W = 8;
    localparam int CODE_W  = 4;
    localparam int HUE_W   = 15;
    localparam int SAT_W   = 13;
    localparam int VAL_W   = 13;

    // Width of one channel level.
    localparam int LVL_W = $clog2(CHANNEL_MAX + 1);
    // Signed width used when a level is formed from a pulse.
    localparam int SUB_W = ((LVL_W > PULSE_W) ? LVL_W : PULSE_W) + 1;

    // Dividend widths: hue numerator stays below 23040 * delta,
    // saturation and value numerators below 8192 * level.
    localparam int HNUM_W = LVL_W + HUE_W;
    localparam int SNUM_W = LVL_W + SAT_W;
    localparam int VNUM_W = LVL_W + VAL_W;

    // Value division by the constant full scale is a multiply by a rounded-up
    // reciprocal; the shift is wide enough for the result to be exact.
    localparam int VAL_S  = VNUM_W + LVL_W;
    localparam int VALM_W = VNUM_W + 2;
    localparam longint unsigned VAL_M_FULL =
        ((64'd1 << VAL_S) + 64'(CHANNEL_MAX) - 64'd1) / 64'(CHANNEL_MAX);
    localparam logic [VALM_W-1:0] VAL_M = VALM_W'(VAL_M_FULL);
    localparam int VALP_W = VNUM_W + VALM_W;

    // Default number of divider stages.
    localparam int DIV_STAGES_DEF = 4;

    typedef enum logic [CODE_W-1:0] {
        COLOR_WHITE   = 4'd0,
        COLOR_RED     = 4'd1,
        COLOR_ORANGE  = 4'd2,
        COLOR_YELLOW  = 4'd3,
        COLOR_GREEN   = 4'd4,
        COLOR_CYAN    = 4'd5,
        COLOR_BLUE    = 4'd6,
        COLOR_VIOLET  = 4'd7,
        COLOR_MAGENTA = 4'd8
    } t_color;

    typedef enum logic [1:0] {
        MAX_RED   = 2'd0,
        MAX_GREEN = 2'd1,
        MAX_BLUE  = 2'd2
    } t_maxsel;

    typedef struct packed {
        logic [PULSE_W-1:0] red_pulse;
        logic [PULSE_W-1:0] green_pulse;
        logic [PULSE_W-1:0] blue_pulse;
        logic [CODE_W-1:0]  color_code;
    } t_in;

    typedef struct packed {
        logic             is_match;
        logic [HUE_W-1:0] hue_x64;
        logic [SAT_W-1:0] sat_x64;
        logic [VAL_W-1:0] value_x64;
    } t_out;

    // What the front stages hand to the dividers.
    typedef struct packed {
        logic [HNUM_W-1:0] hue_num;
        logic [SNUM_W-1:0] sat_num;
        logic [VNUM_W-1:0] val_num;
        logic [LVL_W-1:0]  delta;
        logic [LVL_W-1:0]  mx;
        logic              white;
        logic              gray;
        logic [CODE_W-1:0] code;
    } t_front;

endpackage

@@ design/hcc_front.sv @@
module hcc_front
    import hcc_pkg::*;
(
    input  logic       i_clk,
    input  logic [1:0] i_en,
    input  t_in        i_data,
    output t_front     o_front
);

    localparam int HS_W = HNUM_W + 2;
    localparam int WH_W = LVL_W + 8;

    localparam logic signed [HS_W-1:0] K_SLOPE = HS_W'(3840);
    localparam logic [HUE_W-1:0] BASE_WRAP  = HUE_W'(23040);
    localparam logic [HUE_W-1:0] BASE_GREEN = HUE_W'(7680);
    localparam logic [HUE_W-1:0] BASE_BLUE  = HUE_W'(15360);
    localparam logic [WH_W-1:0]  WHITE_VAL  = WH_W'(97 * CHANNEL_MAX);

    function automatic logic [LVL_W-1:0] level_of(input logic [PULSE_W-1:0] p);
        logic signed [SUB_W-1:0] d;
        d = $signed(SUB_W'(CHANNEL_MAX)) - $signed(SUB_W'(p));
        return d[SUB_W-1] ? '0 : d[LVL_W-1:0];
    endfunction

    // Stage A: levels, extremes and which channel is the maximum.
    logic [LVL_W-1:0]  lv_r, lv_g, lv_b, a_mx, a_mn;
    t_maxsel           a_sel;
    logic [LVL_W-1:0]  r_a_r, r_a_g, r_a_b, r_a_mx, r_a_delta;
    t_maxsel           r_a_sel;
    logic [CODE_W-1:0] r_a_code;

    always_comb begin
        lv_r = level_of(i_data.red_pulse);
        lv_g = level_of(i_data.green_pulse);
        lv_b = level_of(i_data.blue_pulse);
        a_mx = (lv_r > lv_g) ? lv_r : lv_g;
        a_mx = (a_mx > lv_b) ? a_mx : lv_b;
        a_mn = (lv_r < lv_g) ? lv_r : lv_g;
        a_mn = (a_mn < lv_b) ? a_mn : lv_b;
        if (lv_r >= a_mx) begin
            a_sel = MAX_RED;
        end else if (lv_g >= a_mx) begin
            a_sel = MAX_GREEN;
        end else begin
            a_sel = MAX_BLUE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_a_r     <= lv_r;
            r_a_g     <= lv_g;
            r_a_b     <= lv_b;
            r_a_mx    <= a_mx;
            r_a_delta <= a_mx - a_mn;
            r_a_sel   <= a_sel;
            r_a_code  <= i_data.color_code;
        end
    end

    // Stage B: dividends and the white test.
    logic [LVL_W-1:0]        x, y;
    logic signed [LVL_W:0]   diff;
    logic [HUE_W-1:0]        base;
    logic signed [HS_W-1:0]  t_base, t_diff, num;
    t_front                  n_front, r_front;

    always_comb begin
        unique case (r_a_sel)
            MAX_RED: begin
                x = r_a_g;
                y = r_a_b;
            end
            MAX_GREEN: begin
                x = r_a_b;
                y = r_a_r;
            end
            MAX_BLUE: begin
                x = r_a_r;
                y = r_a_g;
            end
            default: begin
                x = '0;
                y = '0;
            end
        endcase
        diff = $signed({1'b0, x}) - $signed({1'b0, y});
        case (r_a_sel)
            MAX_RED:   base = diff[LVL_W] ? BASE_WRAP : '0;
            MAX_GREEN: base = BASE_GREEN;
            default:   base = BASE_BLUE;
        endcase
        t_base = $signed(HS_W'(base) * HS_W'(r_a_delta));
        t_diff = {{(HS_W - LVL_W - 1){diff[LVL_W]}}, diff};
        num    = t_base + t_diff * K_SLOPE;

        n_front.hue_num = num[HNUM_W-1:0];
        n_front.sat_num = SNUM_W'(r_a_delta) * SNUM_W'(6400);
        n_front.val_num = VNUM_W'(r_a_mx) * VNUM_W'(6400);
        n_front.delta   = r_a_delta;
        n_front.mx      = r_a_mx;
        n_front.white   = (WH_W'(r_a_mx) * WH_W'(100) > WHITE_VAL) &&
                          (WH_W'(r_a_delta) * WH_W'(100) < WH_W'(r_a_mx) * WH_W'(5));
        n_front.gray    = (r_a_delta == '0);
        n_front.code    = r_a_code;
    end

    always_ff @(posedge i_clk) begin
        if (i_en[1]) begin
            r_front <= n_front;
        end
    end

    assign o_front = r_front;

endmodule

@@ design/hcc_div.sv @@
module hcc_div
    import hcc_pkg::*;
#(
    parameter int NW  = HNUM_W,
    parameter int DW  = LVL_W,
    parameter int QW  = HUE_W,
    parameter int STG = DIV_STAGES_DEF
) (
    input  logic           i_clk,
    input  logic [STG-1:0] i_en,
    input  logic [NW-1:0]  i_num,
    input  logic [DW-1:0]  i_den,
    output logic [QW-1:0]  o_quo
);

    localparam int BPS = (QW + STG - 1) / STG;
    localparam int QP  = BPS * STG;
    localparam int XW  = QP + DW;

    // Each stage holds the partial remainder and a word that starts as the
    // low dividend bits and fills with quotient bits as they shift out.
    logic [XW-1:0] num_x;
    logic [DW-1:0] r_rem [STG];
    logic [DW-1:0] r_den [STG];
    logic [QP-1:0] r_lq  [STG];
    logic [DW-1:0] n_rem [STG];
    logic [QP-1:0] n_lq  [STG];

    assign num_x = XW'(i_num);

    always_comb begin
        logic [DW-1:0] rem, den;
        logic [QP-1:0] lq;
        logic [DW:0]   t;
        for (int k = 0; k < STG; k++) begin
            if (k == 0) begin
                rem = num_x[XW-1:QP];
                lq  = num_x[QP-1:0];
                den = i_den;
            end else begin
                rem = r_rem[k-1];
                lq  = r_lq[k-1];
                den = r_den[k-1];
            end
            for (int s = 0; s < BPS; s++) begin
                t = {rem, lq[QP-1]};
                if (t >= {1'b0, den}) begin
                    rem = DW'(t - {1'b0, den});
                    lq  = {lq[QP-2:0], 1'b1};
                end else begin
                    rem = t[DW-1:0];
                    lq  = {lq[QP-2:0], 1'b0};
                end
            end
            n_rem[k] = rem;
            n_lq[k]  = lq;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < STG; k++) begin
            if (i_en[k]) begin
                r_rem[k] <= n_rem[k];
                r_lq[k]  <= n_lq[k];
                r_den[k] <= (k == 0) ? i_den : r_den[(k == 0) ? 0 : k - 1];
            end
        end
    end

    assign o_quo = r_lq[STG-1][QW-1:0];

endmodule

@@ design/rgb_hue_color_classifier.sv @@
// Color classifier for a stream of RGB pulse-width readings.
//
// Input channel (i_valid / o_ready / i_data): one reading per transfer, made
// of three pulse widths and a requested color code. Output channel (o_valid /
// i_ready / o_data): one result per reading, in order, with the match flag
// and the hue, saturation and value of the reading in 1/64 units.
//
// The datapath is a pipeline of DIV_STAGES + 3 register stages: two front
// stages form the levels and the dividends, DIV_STAGES stages run the hue
// and saturation dividers side by side, and a final output register holds
// the band decision. A new reading is taken every cycle unless a stall at
// i_ready has filled the pipeline; the rate is set by the per-stage
// handshake, with no shared unit.
//
// Each stage has its own valid bit. A stage loads when it is empty or when
// the stage after it loads, so a stall at i_ready fills bubbles first and
// only then drops o_ready; nothing is lost or repeated. Reset (synchronous,
// active low) clears every valid bit; the data registers are not reset.
module rgb_hue_color_classifier
    import hcc_pkg::*;
#(
    parameter int DIV_STAGES = DIV_STAGES_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    input  t_in  i_data,
    output logic o_valid,
    input  logic i_ready,
    output t_out o_data
);

    // Stage 0 and 1 sit in the front, then the divider stages, then the
    // output register.
    localparam int NSTG = DIV_STAGES + 3;
    localparam int DLST = DIV_STAGES - 1;

    // Hue band edges in 1/64 degree.
    localparam logic [HUE_W-1:0] H_15  = HUE_W'(15 * 64);
    localparam logic [HUE_W-1:0] H_25  = HUE_W'(25 * 64);
    localparam logic [HUE_W-1:0] H_75  = HUE_W'(75 * 64);
    localparam logic [HUE_W-1:0] H_165 = HUE_W'(165 * 64);
    localparam logic [HUE_W-1:0] H_220 = HUE_W'(220 * 64);
    localparam logic [HUE_W-1:0] H_235 = HUE_W'(235 * 64);
    localparam logic [HUE_W-1:0] H_270 = HUE_W'(270 * 64);
    localparam logic [HUE_W-1:0] H_330 = HUE_W'(330 * 64);

    function automatic logic band_match(input logic [HUE_W-1:0]  hue,
                                        input logic [CODE_W-1:0] code,
                                        input logic              white);
        logic m;
        unique case (t_color'(code))
            COLOR_WHITE:   m = white;
            COLOR_RED:     m = (hue >= H_330) || (hue < H_15);
            COLOR_ORANGE:  m = (hue >= H_15)  && (hue < H_25);
            COLOR_YELLOW:  m = (hue >= H_25)  && (hue < H_75);
            COLOR_GREEN:   m = (hue >= H_75)  && (hue < H_165);
            COLOR_CYAN:    m = (hue >= H_165) && (hue < H_220);
            COLOR_BLUE:    m = (hue >= H_220) && (hue < H_235);
            COLOR_VIOLET:  m = (hue >= H_235) && (hue < H_270);
            COLOR_MAGENTA: m = (hue >= H_270) && (hue < H_330);
            default:       m = 1'b0;
        endcase
        return m;
    endfunction

    // Handshake: a stage is ready when it is empty or its successor loads.
    logic [NSTG-1:0] r_vld;
    logic [NSTG-1:0] rdy;
    logic [NSTG-1:0] vin;
    logic [NSTG-1:0] ld;

    always_comb begin
        rdy[NSTG-1] = !r_vld[NSTG-1] || i_ready;
        for (int k = NSTG - 2; k >= 0; k--) begin
            rdy[k] = !r_vld[k] || rdy[k+1];
        end
        vin = {r_vld[NSTG-2:0], i_valid};
        ld  = rdy & vin;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            for (int k = 0; k < NSTG; k++) begin
                if (rdy[k]) begin
                    r_vld[k] <= vin[k];
                end
            end
        end
    end

    assign o_ready = rdy[0];

    // Front: levels, max/min, dividends, white test.
    t_front front;

    hcc_front u_front (
        .i_clk   (i_clk),
        .i_en    (ld[1:0]),
        .i_data  (i_data),
        .o_front (front)
    );

    // Hue = hue_num / delta and saturation = sat_num / max, both truncated.
    logic [HUE_W-1:0] hue_q;
    logic [SAT_W-1:0] sat_q;

    hcc_div #(
        .NW  (HNUM_W),
        .DW  (LVL_W),
        .QW  (HUE_W),
        .STG (DIV_STAGES)
    ) u_div_hue (
        .i_clk (i_clk),
        .i_en  (ld[DIV_STAGES+1:2]),
        .i_num (front.hue_num),
        .i_den (front.delta),
        .o_quo (hue_q)
    );

    hcc_div #(
        .NW  (SNUM_W),
        .DW  (LVL_W),
        .QW  (SAT_W),
        .STG (DIV_STAGES)
    ) u_div_sat (
        .i_clk (i_clk),
        .i_en  (ld[DIV_STAGES+1:2]),
        .i_num (front.sat_num),
        .i_den (front.mx),
        .o_quo (sat_q)
    );

    // Side band that rides along with the dividers. Value is the exact
    // quotient by the full scale, done as a reciprocal multiply in the
    // first divider stage.
    logic [CODE_W-1:0] r_code  [DIV_STAGES];
    logic              r_white [DIV_STAGES];
    logic              r_gray  [DIV_STAGES];
    logic [VAL_W-1:0]  r_val   [DIV_STAGES];
    logic [VALP_W-1:0] val_prod;

    assign val_prod = VALP_W'(front.val_num) * VALP_W'(VAL_M);

    always_ff @(posedge i_clk) begin
        if (ld[2]) begin
            r_code[0]  <= front.code;
            r_white[0] <= front.white;
            r_gray[0]  <= front.gray;
            r_val[0]   <= val_prod[VAL_S +: VAL_W];
        end
        for (int k = 1; k < DIV_STAGES; k++) begin
            if (ld[2+k]) begin
                r_code[k]  <= r_code[k-1];
                r_white[k] <= r_white[k-1];
                r_gray[k]  <= r_gray[k-1];
                r_val[k]   <= r_val[k-1];
            end
        end
    end

    // Output stage. A gray reading (all levels equal) has zero hue and
    // saturation; the hue divider sees a zero divisor then, and both
    // quotients are dropped.
    t_out n_out, r_out;

    always_comb begin
        n_out.hue_x64   = r_gray[DLST] ? '0 : hue_q;
        n_out.sat_x64   = r_gray[DLST] ? '0 : sat_q;
        n_out.value_x64 = r_val[DLST];
        n_out.is_match  = band_match(n_out.hue_x64, r_code[DLST], r_white[DLST]);
    end

    always_ff @(posedge i_clk) begin
        if (ld[NSTG-1]) begin
            r_out <= n_out;
        end
    end

    assign o_valid = r_vld[NSTG-1];
    assign o_data  = r_out;

endmodule

@@ design/hcc_checker.sv @@
module hcc_checker
    import hcc_pkg::*;
(
    input logic i_clk,
    input logic i_rst_n,
    input logic i_valid,
    input logic i_ready,
    input t_out i_data
);

    localparam logic [HUE_W-1:0] HUE_LIMIT = HUE_W'(23040);
    localparam logic [SAT_W-1:0] PCT_LIMIT = SAT_W'(6400);

    // A result held back by the receiver stays put.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_ready |=> i_valid && $stable(i_data))
        else $error("result changed or dropped while stalled");

    // Hue stays below a full turn, saturation and value at most 100 percent.
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid |-> (i_data.hue_x64 < HUE_LIMIT) && (i_data.sat_x64 <= PCT_LIMIT) &&
                    (i_data.value_x64 <= PCT_LIMIT))
        else $error("hue, saturation or value out of range");

    // Zero saturation only comes from a gray reading, which has zero hue.
    a_gray_hue: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && (i_data.sat_x64 == '0) |-> (i_data.hue_x64 == '0))
        else $error("gray reading with nonzero hue");

    // Reset empties the pipeline.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_valid)
        else $error("result valid right after reset");

endmodule

bind rgb_hue_color_classifier hcc_checker u_hcc_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_valid (o_valid),
    .i_ready (i_ready),
    .i_data  (o_data)
);

@@ test/rgb_hue_color_classifier_tb.sv @@
module rgb_hue_color_classifier_tb;
    import hcc_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // Lower band edges in degrees. Each band runs from its own edge up to the
    // next one, and red wraps around from its edge through 0 to orange.
    localparam int BAND_ORANGE  = 15;
    localparam int BAND_YELLOW  = 25;
    localparam int BAND_GREEN   = 75;
    localparam int BAND_CYAN    = 165;
    localparam int BAND_BLUE    = 220;
    localparam int BAND_VIOLET  = 235;
    localparam int BAND_MAGENTA = 270;
    localparam int BAND_RED     = 330;

    // White needs a bright reading with almost no color in it.
    localparam int WHITE_VAL_PCT = 97;
    localparam int WHITE_SAT_PCT = 5;

    // Codes past magenta name no color and must never match.
    localparam logic [CODE_W-1:0] CODE_UNKNOWN_LO = 4'd9;
    localparam logic [CODE_W-1:0] CODE_UNKNOWN_HI = 4'd15;

    // Pipeline depth at the default divider setting; the drain at the end
    // waits a few times this long so that a stray extra result is caught.
    localparam int LATENCY      = DIV_STAGES_DEF + 3;
    localparam int DRAIN_CYCLES = 4 * LATENCY;

    // The long receiver hold-off must be far longer than the pipeline is
    // deep so that the input side is forced to stall.
    localparam int HOLD_CYCLES = 120;

    // The watchdog fires after this many cycles with no transfer on either
    // side. The slowest legal stretch is the hold-off above plus one idle
    // burst on each side, so this leaves a wide margin.
    localparam int WATCHDOG_LIMIT = 2000;

    localparam int MAX_REPORTS = 10;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic i_ready = 1'b0;
    t_in  i_data  = '0;
    logic o_ready;
    logic o_valid;
    t_out o_data;

    // Expected results in the order the readings were accepted.
    t_out expected_hsv[$];

    int  mismatch_cnt = 0;
    int  quiet_cycles = 0;

    // Idling controls. The sender and receiver each consult their own flag;
    // hold_req asks the receiver for one long hold-off.
    bit  tx_idle  = 1'b0;
    bit  rx_idle  = 1'b0;
    bit  hold_req = 1'b0;

    rgb_hue_color_classifier dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_data  (i_data),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_data  (o_data)
    );

    always #10 i_clk = ~i_clk;

    // Channel level: full scale minus the pulse width, never below zero.
    function automatic longint channel_level(logic [PULSE_W-1:0] pulse);
        longint lvl;
        lvl = longint'(CHANNEL_MAX) - longint'(pulse);
        return (lvl < 0) ? 0 : lvl;
    endfunction

    // True when a hue in 1/64 degree lies in [lo_deg, hi_deg).
    function automatic bit in_hue_band(longint hue, int lo_deg, int hi_deg);
        return (hue >= lo_deg * 64) && (hue < hi_deg * 64);
    endfunction

    // Computes hue, saturation and value of one reading with exact integer
    // arithmetic, then decides whether it falls in the requested band.
    function automatic t_out classify_reading(t_in rd);
        longint r, g, b, mx, mn, delta, hue, sat, val, num;
        bit     white, hit;
        t_out   res;
        r = channel_level(rd.red_pulse);
        g = channel_level(rd.green_pulse);
        b = channel_level(rd.blue_pulse);
        mx = (r > g) ? r : g;
        mx = (mx > b) ? mx : b;
        mn = (r < g) ? r : g;
        mn = (mn < b) ? mn : b;
        delta = mx - mn;
        hue = 0;
        sat = 0;
        val = (mx * 6400) / CHANNEL_MAX;
        // A gray reading keeps hue and saturation at zero.
        if (delta > 0) begin
            sat = (delta * 6400) / mx;
            // Red wins ties, then green. A negative red hue wraps by 360
            // degrees, folded into the numerator so it stays positive.
            if (r >= mx) begin
                if (g >= b) begin
                    num = 3840 * (g - b);
                end else begin
                    num = 23040 * delta + 3840 * (g - b);
                end
            end else if (g >= mx) begin
                num = 7680 * delta + 3840 * (b - r);
            end else begin
                num = 15360 * delta + 3840 * (r - g);
            end
            hue = num / delta;
        end
        white = (mx * 100 > WHITE_VAL_PCT * CHANNEL_MAX) &&
                (delta * 100 < WHITE_SAT_PCT * mx);
        case (rd.color_code)
            COLOR_WHITE:   hit = white;
            COLOR_RED:     hit = (hue >= BAND_RED * 64) || (hue < BAND_ORANGE * 64);
            COLOR_ORANGE:  hit = in_hue_band(hue, BAND_ORANGE, BAND_YELLOW);
            COLOR_YELLOW:  hit = in_hue_band(hue, BAND_YELLOW, BAND_GREEN);
            COLOR_GREEN:   hit = in_hue_band(hue, BAND_GREEN, BAND_CYAN);
            COLOR_CYAN:    hit = in_hue_band(hue, BAND_CYAN, BAND_BLUE);
            COLOR_BLUE:    hit = in_hue_band(hue, BAND_BLUE, BAND_VIOLET);
            COLOR_VIOLET:  hit = in_hue_band(hue, BAND_VIOLET, BAND_MAGENTA);
            COLOR_MAGENTA: hit = in_hue_band(hue, BAND_MAGENTA, BAND_RED);
            default:       hit = 1'b0;
        endcase
        res.is_match  = hit;
        res.hue_x64   = HUE_W'(hue);
        res.sat_x64   = SAT_W'(sat);
        res.value_x64 = VAL_W'(val);
        return res;
    endfunction

    function automatic t_in make_reading(int rp, int gp, int bp, logic [CODE_W-1:0] code);
        t_in rd;
        rd.red_pulse   = PULSE_W'(rp);
        rd.green_pulse = PULSE_W'(gp);
        rd.blue_pulse  = PULSE_W'(bp);
        rd.color_code  = code;
        return rd;
    endfunction

    // Random readings come in three flavors. Plain uniform pulses cover every
    // bit; near-white readings probe the white thresholds; pulses pinned to
    // the rails give saturated colors and exact ties between channels. Most
    // codes name a real color, the rest are drawn from every code value.
    function automatic t_in random_reading();
        t_in rd;
        int  flavor;
        int  k;
        flavor = $urandom_range(0, 3);
        case (flavor)
            0, 1: begin
                rd.red_pulse   = PULSE_W'($urandom);
                rd.green_pulse = PULSE_W'($urandom);
                rd.blue_pulse  = PULSE_W'($urandom);
            end
            2: begin
                k = $urandom_range(0, 16);
                rd.red_pulse   = PULSE_W'($urandom_range(0, k));
                rd.green_pulse = PULSE_W'($urandom_range(0, k));
                rd.blue_pulse  = PULSE_W'($urandom_range(0, k));
            end
            default: begin
                k = $urandom_range(0, 255);
                rd.red_pulse   = ($urandom_range(0, 2) == 0) ? PULSE_W'(k) :
                                 (($urandom_range(0, 1) == 0) ? 8'd0 : 8'd255);
                rd.green_pulse = ($urandom_range(0, 2) == 0) ? PULSE_W'($urandom) :
                                 (($urandom_range(0, 1) == 0) ? 8'd0 : PULSE_W'(k));
                rd.blue_pulse  = ($urandom_range(0, 2) == 0) ? PULSE_W'($urandom) :
                                 (($urandom_range(0, 1) == 0) ? 8'd255 : PULSE_W'(k));
            end
        endcase
        if ($urandom_range(0, 4) != 0) begin
            rd.color_code = CODE_W'($urandom_range(COLOR_WHITE, COLOR_MAGENTA));
        end else begin
            rd.color_code = CODE_W'($urandom);
        end
        return rd;
    endfunction

    // Offers one reading and waits for its transfer. When sender idling is
    // on, valid may first drop for a random burst. The task is always entered
    // and left at a rising edge, so valid gets at most one update per step.
    task automatic send_reading(input t_in rd);
        int gap;
        if (tx_idle && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 15);
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_data  <= rd;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        expected_hsv.push_back(classify_reading(rd));
    endtask

    task automatic send_random(input int count);
        repeat (count) send_reading(random_reading());
    endtask

    // Extremes of every field, each color code, the white thresholds on both
    // sides, gray and black readings, the wrap of hue near 360 degrees, and
    // unknown codes.
    task automatic test_directed();
        tx_idle = 1'b0;
        rx_idle = 1'b0;
        send_reading(make_reading(0, 0, 0, COLOR_WHITE));
        send_reading(make_reading(0, 12, 0, COLOR_WHITE));
        send_reading(make_reading(0, 13, 0, COLOR_WHITE));
        send_reading(make_reading(7, 7, 7, COLOR_WHITE));
        send_reading(make_reading(8, 8, 8, COLOR_WHITE));
        // Gray and black readings have zero hue and land in the red band.
        send_reading(make_reading(255, 255, 255, COLOR_RED));
        send_reading(make_reading(128, 128, 128, COLOR_RED));
        send_reading(make_reading(0, 255, 255, COLOR_RED));
        send_reading(make_reading(0, 170, 255, COLOR_ORANGE));
        send_reading(make_reading(0, 0, 255, COLOR_YELLOW));
        send_reading(make_reading(255, 0, 255, COLOR_GREEN));
        send_reading(make_reading(255, 0, 0, COLOR_CYAN));
        send_reading(make_reading(255, 204, 0, COLOR_BLUE));
        send_reading(make_reading(255, 255, 0, COLOR_VIOLET));
        send_reading(make_reading(0, 255, 0, COLOR_MAGENTA));
        // Red is maximal with blue above green, so the hue wraps to just
        // below 360 degrees.
        send_reading(make_reading(0, 255, 254, COLOR_RED));
        send_reading(make_reading(255, 255, 254, COLOR_VIOLET));
        send_reading(make_reading(8'hAA, 8'h55, 8'hFF, COLOR_CYAN));
        send_reading(make_reading(8'h55, 8'hAA, 8'h00, COLOR_GREEN));
        send_reading(make_reading(0, 0, 0, CODE_UNKNOWN_LO));
        send_reading(make_reading(0, 255, 255, CODE_UNKNOWN_HI));
    endtask

    task automatic test_random_idle();
        tx_idle = 1'b1;
        rx_idle = 1'b1;
        send_random(700);
    endtask

    // The receiver holds off for a long stretch while readings keep coming
    // back to back, so the pipeline fills and o_ready must drop.
    task automatic test_backpressure();
        tx_idle  = 1'b0;
        rx_idle  = 1'b1;
        hold_req = 1'b1;
        send_random(150);
    endtask

    // Full rate on both sides to close the run.
    task automatic test_streaming();
        tx_idle = 1'b0;
        rx_idle = 1'b0;
        send_random(300);
    endtask

    // Receiver: alternates ready stretches with stall bursts, and takes one
    // long hold-off on request. Each branch makes a single update of i_ready
    // and then lets at least one edge pass.
    initial begin
        wait (i_rst_n);
        @(posedge i_clk);
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                i_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else if (rx_idle && $urandom_range(0, 3) == 0) begin
                i_ready <= 1'b0;
                repeat ($urandom_range(1, 15)) @(posedge i_clk);
            end else begin
                i_ready <= 1'b1;
                repeat ($urandom_range(1, 20)) @(posedge i_clk);
            end
        end
    end

    // Result check: every output transfer is compared field by field with
    // the oldest expectation. Values are read at the edge, before any update
    // scheduled by that edge has been applied.
    always @(posedge i_clk) begin
        t_out want;
        if (i_rst_n && o_valid && i_ready) begin
            if (expected_hsv.size() == 0) begin
                mismatch_cnt++;
                if (mismatch_cnt <= MAX_REPORTS) begin
                    $display("unexpected result: match %0b hue %0d sat %0d value %0d",
                             o_data.is_match, o_data.hue_x64, o_data.sat_x64,
                             o_data.value_x64);
                end
            end else begin
                want = expected_hsv.pop_front();
                if (o_data.is_match !== want.is_match || o_data.hue_x64 !== want.hue_x64 ||
                    o_data.sat_x64 !== want.sat_x64 ||
                    o_data.value_x64 !== want.value_x64) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= MAX_REPORTS) begin
                        $display("mismatch: expected match %0b hue %0d sat %0d value %0d",
                                 want.is_match, want.hue_x64, want.sat_x64,
                                 want.value_x64);
                        $display("          actual   match %0b hue %0d sat %0d value %0d",
                                 o_data.is_match, o_data.hue_x64, o_data.sat_x64,
                                 o_data.value_x64);
                    end
                end
            end
        end
    end

    // Watchdog: counts cycles in which no transfer happens on either side.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("rgb_hue_color_classifier_tb: done, errors");
            $finish;
        end
    end

    // Sequence: reset once, run each test in turn, then drain and report.
    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random_idle();
        test_backpressure();
        test_streaming();
        i_valid <= 1'b0;
        while (expected_hsv.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_cnt == 0) begin
            $display("rgb_hue_color_classifier_tb: done, clean");
        end else begin
            $display("rgb_hue_color_classifier_tb: done, errors");
        end
        $finish;
    end

endmodule
